>>> rtl/core/bpms_pkg.sv
package bpms_pkg;

    localparam int NUM_GROUPS = 32;
    localparam int GRP_W      = 5;
    localparam int PERIOD_W   = 16;
    localparam int SIZE_W     = 8;
    localparam int TICK_W     = 32;
    localparam int BIT_W      = 5;
    localparam logic [SIZE_W-1:0] BUDGET_RESET = 8'd30;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                is_tick;
        logic                write_ok;
        logic [GRP_W-1:0]    idx;
        logic [PERIOD_W-1:0] period;
        logic [SIZE_W-1:0]   size;
    } bpms_cmd_t;

endpackage

>>> rtl/core/bpms_if.sv
interface bpms_req_if;
    import bpms_pkg::*;
    logic                valid;
    logic                ready;
    logic                command;
    logic [GRP_W-1:0]    group_index;
    logic [PERIOD_W-1:0] period;
    logic [SIZE_W-1:0]   byte_size;
    modport source (output valid, command, group_index, period, byte_size, input ready);
    modport sink   (input valid, command, group_index, period, byte_size, output ready);
endinterface

interface bpms_rsp_if;
    import bpms_pkg::*;
    logic              valid;
    logic              ready;
    logic [GRP_W-1:0]  sent_group;
    logic              sent;
    logic [SIZE_W-1:0] budget_left;
    logic              last;
    modport source (output valid, sent_group, sent, budget_left, last, input ready);
    modport sink   (input valid, sent_group, sent, budget_left, last, output ready);
endinterface

interface bpms_cfg_if;
    import bpms_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/bpms_front.sv
module bpms_front (
    input  logic               clk,
    input  logic               rst_n,
    bpms_req_if.sink           req,
    output bpms_pkg::bpms_cmd_t q_data,
    output logic               q_valid,
    input  logic               q_pop
);
    import bpms_pkg::*;

    bpms_cmd_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    bpms_cmd_t  cls;

    // classify: tick or write, and whether the write index exists
    always_comb
    begin
        cls.is_tick  = (req.command == CMD_TICK);
        cls.write_ok = ({1'b0, req.group_index} < (GRP_W+1)'(NUM_GROUPS));
        cls.idx      = req.group_index;
        cls.period   = req.period;
        cls.size     = req.byte_size;
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_data    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0) else $error("pop from empty queue");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("pointers disagree with count");

endmodule

>>> rtl/core/bpms_back.sv
module bpms_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bpms_pkg::bpms_cmd_t q_data,
    input  logic                q_valid,
    output logic                q_pop,
    bpms_cfg_if.sink            cfg,
    bpms_rsp_if.source          rsp
);
    import bpms_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [PERIOD_W-1:0] period_reg [NUM_GROUPS];
    logic [SIZE_W-1:0]   size_reg   [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] pend_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [SIZE_W-1:0]   budget_reg;
    logic [SIZE_W-1:0]   left_reg, left_next;
    logic [GRP_W-1:0]    grp_reg, grp_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W:0]   shifted;
    logic                hold_valid_reg, hold_valid_next;
    logic [GRP_W-1:0]    hold_grp_reg, hold_grp_next;
    logic [SIZE_W-1:0]   hold_left_reg, hold_left_next;
    logic                out_valid_reg, out_valid_next;
    logic [GRP_W-1:0]    out_grp_reg, out_grp_next;
    logic                out_sent_reg, out_sent_next;
    logic [SIZE_W-1:0]   out_left_reg, out_left_next;
    logic                out_last_reg, out_last_next;
    logic                out_free, last_grp, due, fits;
    logic                wr_en, pend_set, pend_clr, tick_inc;

    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.sent_group  = out_grp_reg;
    assign rsp.sent        = out_sent_reg;
    assign rsp.budget_left = out_left_reg;
    assign rsp.last        = out_last_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign last_grp = (grp_reg == GRP_W'(NUM_GROUPS-1));
    assign shifted  = {rem_reg, tick_reg[~bit_reg]};
    assign due      = (rem_reg == '0) || pend_reg[grp_reg];
    assign fits     = (left_reg >= size_reg[grp_reg]);

    always_comb
    begin
        state_next      = state_reg;
        left_next       = left_reg;
        grp_next        = grp_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        hold_valid_next = hold_valid_reg;
        hold_grp_next   = hold_grp_reg;
        hold_left_next  = hold_left_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_grp_next    = out_grp_reg;
        out_sent_next   = out_sent_reg;
        out_left_next   = out_left_reg;
        out_last_next   = out_last_reg;
        q_pop    = 1'b0;
        wr_en    = 1'b0;
        pend_set = 1'b0;
        pend_clr = 1'b0;
        tick_inc = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_data.is_tick)
                    begin
                        grp_next   = '0;
                        left_next  = budget_reg;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        wr_en = q_data.write_ok;
                    end
                end
            end
            ST_LOAD:
            begin
                // skip disabled groups
                if (period_reg[grp_reg] == '0)
                begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = last_grp ? ST_FIN : ST_LOAD;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one restoring step of tick % period per cycle
                if (shifted >= {1'b0, period_reg[grp_reg]})
                begin
                    rem_next = PERIOD_W'(shifted - {1'b0, period_reg[grp_reg]});
                end
                else
                begin
                    rem_next = PERIOD_W'(shifted);
                end
                bit_next = bit_reg + 1'b1;
                if (bit_reg == '1)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (due && fits)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_grp_next   = hold_grp_reg;
                            out_sent_next  = 1'b1;
                            out_left_next  = hold_left_reg;
                            out_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_grp_next   = grp_reg;
                        hold_left_next  = left_reg - size_reg[grp_reg];
                        left_next       = left_reg - size_reg[grp_reg];
                        pend_clr        = 1'b1;
                        grp_next        = grp_reg + 1'b1;
                        state_next      = last_grp ? ST_FIN : ST_LOAD;
                    end
                end
                else
                begin
                    pend_set   = due;
                    grp_next   = grp_reg + 1'b1;
                    state_next = last_grp ? ST_FIN : ST_LOAD;
                end
            end
            ST_FIN:
            begin
                // close the tick: held result carries last, else report no send
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_grp_next    = hold_valid_reg ? hold_grp_reg : '0;
                    out_sent_next   = hold_valid_reg;
                    out_left_next   = hold_valid_reg ? hold_left_reg : budget_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    tick_inc        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        left_reg      <= left_next;
        bit_reg       <= bit_next;
        rem_reg       <= rem_next;
        hold_grp_reg  <= hold_grp_next;
        hold_left_reg <= hold_left_next;
        out_grp_reg   <= out_grp_next;
        out_sent_reg  <= out_sent_next;
        out_left_reg  <= out_left_next;
        out_last_reg  <= out_last_next;
        grp_reg       <= grp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= '0;
            tick_reg       <= '0;
            budget_reg     <= BUDGET_RESET;
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                period_reg[i] <= '0;
                size_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                budget_reg <= cfg.data;
            end
            if (wr_en)
            begin
                period_reg[q_data.idx] <= q_data.period;
                size_reg[q_data.idx]   <= q_data.size;
            end
            if (pend_set)
            begin
                pend_reg[grp_reg] <= 1'b1;
            end
            if (pend_clr)
            begin
                pend_reg[grp_reg] <= 1'b0;
            end
            if (tick_inc)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
        end
    end

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !hold_valid_reg) else $error("held result outside a tick");
    a_unsent_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_sent_reg |-> out_last_reg)
        else $error("empty result not marked last");
    a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> hold_left_reg <= budget_reg) else $error("budget grew");
    a_fin_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_inc |=> out_valid_reg && out_last_reg) else $error("tick closed without last");

endmodule

>>> rtl/core/budgeted_periodic_message_scheduler.sv
// Budgeted periodic message scheduler.
// Channels: req carries items (command 0 = tick, 1 = write a group's period
// and byte size); rsp returns one item per group sent on a tick, or a single
// item with sent = 0 and the full budget when nothing went out; the final
// item of each tick has last set. cfg writes the per-tick byte budget and is
// always ready; write it only while the block is idle.
// Operation: with the scheduler idle, a write is stored in the queue and then
// written into the table when the scheduler pops it. A tick walks all 32 groups
// in order; an enabled group passes through load, a 32-step restoring
// tick % period unit and decide, and a disabled one is skipped in load. The
// tick is popped first and closed last; every enabled group uses the shared
// one-bit-per-cycle modulo unit in turn.
// A two-entry queue parts the intake from the scheduler, so items are taken
// while a tick is in progress until the queue fills.
// Reset clears all periods, sizes, pending marks and the tick counter and
// sets the budget to 30. When the receiver stalls, results wait in the
// output register and a one-deep hold stage and the walk pauses.
module budgeted_periodic_message_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    bpms_req_if.sink    req,
    bpms_cfg_if.sink    cfg,
    bpms_rsp_if.source  rsp
);
    import bpms_pkg::*;

    bpms_cmd_t q_data;
    logic      q_valid;
    logic      q_pop;

    // intake and command queue
    bpms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // table update and tick walk
    bpms_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

>>> tb/bpms_tb_if.sv
// Channel interfaces are provided by the RTL (bpms_if.sv); this file holds
// the testbench-side bundle of stall and burst knobs shared by the drivers.
interface bpms_tb_ctl_if;
    timeunit 1ns;
    timeprecision 1ps;
    logic       quiet;      // when high, no idling on either side
    logic [3:0] stall_pct;  // receiver stall weight, out of 16
endinterface

>>> tb/tb_budgeted_periodic_message_scheduler.sv
module tb_budgeted_periodic_message_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import bpms_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 430;

    logic clk;
    logic rst_n;

    bpms_req_if    req ();
    bpms_cfg_if    cfg ();
    bpms_rsp_if    rsp ();
    bpms_tb_ctl_if ctl ();

    budgeted_periodic_message_scheduler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .cfg   (cfg.sink),
        .rsp   (rsp.source)
    );

    // One expected send record per result item.
    typedef struct packed {
        logic [GRP_W-1:0]  grp;
        logic              snt;
        logic [SIZE_W-1:0] left;
        logic              lst;
    } send_rec_t;

    // One row of the directed table. Rows with has_exp carry a hand-typed
    // single result that is checked against the predictor's own answer too.
    typedef struct packed {
        logic                cmd;
        logic [GRP_W-1:0]    idx;
        logic [PERIOD_W-1:0] per;
        logic [SIZE_W-1:0]   sz;
        logic                has_exp;
        send_rec_t           exp;
    } dir_row_t;

    // Shadow of the scheduler state.
    logic [PERIOD_W-1:0] sh_period [NUM_GROUPS];
    logic [SIZE_W-1:0]   sh_size   [NUM_GROUPS];
    logic                sh_pend   [NUM_GROUPS];
    logic [TICK_W-1:0]   sh_tick;
    logic [SIZE_W-1:0]   sh_budget;

    send_rec_t sends_due[$];
    int        fail_count;
    int        idle_cycles;
    bit        stim_done;

    always #5 clk = ~clk;

    // Walk the shadow table for one item; push every expected send.
    task automatic schedule_item(input logic c, input logic [GRP_W-1:0] ix,
                                 input logic [PERIOD_W-1:0] p,
                                 input logic [SIZE_W-1:0] s);
        int        left;
        int        n;
        send_rec_t r;
        if (c == CMD_WRITE) begin
            sh_period[ix] = p;
            sh_size[ix]   = s;
            return;
        end
        left = sh_budget;
        n    = 0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (sh_period[g] == 0)
                continue;
            if ((sh_tick % sh_period[g]) == 0 || sh_pend[g]) begin
                if (left >= sh_size[g]) begin
                    left -= sh_size[g];
                    sh_pend[g] = 1'b0;
                    r = '{grp: g[GRP_W-1:0], snt: 1'b1, left: left[SIZE_W-1:0],
                          lst: 1'b0};
                    sends_due.push_back(r);
                    n++;
                end
                else begin
                    sh_pend[g] = 1'b1;
                end
            end
        end
        sh_tick = sh_tick + 1;
        if (n == 0) begin
            r = '{grp: '0, snt: 1'b0, left: sh_budget, lst: 1'b1};
            sends_due.push_back(r);
        end
        else begin
            sends_due[$].lst = 1'b1;
        end
    endtask

    // Send one item: hold valid until accepted; items come in bursts split by gaps.
    task automatic send_item(input logic c, input logic [GRP_W-1:0] ix,
                             input logic [PERIOD_W-1:0] p,
                             input logic [SIZE_W-1:0] s);
        req.valid       <= 1'b1;
        req.command     <= c;
        req.group_index <= ix;
        req.period      <= p;
        req.byte_size   <= s;
        do
            @(posedge clk);
        while (!req.ready);
        schedule_item(c, ix, p, s);
        // End of a burst: drop valid for a random gap.
        if (!ctl.quiet && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic finish_item_stream();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for all expected sends, plus the longest walk time.
    task automatic drain();
        while (sends_due.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_budget(input logic [SIZE_W-1:0] b);
        cfg.valid <= 1'b1;
        cfg.data  <= b;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        sh_budget = b;
    endtask

    // Random item: mostly ticks over a small table of short periods, so that
    // budgets overflow and pending groups pile up; some wide-field noise.
    task automatic random_item();
        logic [PERIOD_W-1:0] p;
        int                  k;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            send_item(CMD_TICK, GRP_W'($urandom), PERIOD_W'($urandom),
                      SIZE_W'($urandom));
        end
        else begin
            if (k < 85)
                p = PERIOD_W'($urandom_range(0, 6));
            else if (k < 95)
                p = PERIOD_W'($urandom);
            else
                p = '0;
            send_item(CMD_WRITE, GRP_W'($urandom), p,
                      ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom)
                                                  : SIZE_W'($urandom_range(0, 20)));
        end
    endtask

    // Receiver: stall pattern of its own, with quiet stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (ctl.quiet)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 15) >= ctl.stall_pct);
    end

    // Compare each accepted result with the oldest expected send.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready) begin
            if (sends_due.size() == 0) begin
                $display("%0t: unexpected result grp=%0d sent=%0b left=%0d last=%0b",
                         $time, rsp.sent_group, rsp.sent, rsp.budget_left, rsp.last);
                fail_count++;
            end
            else begin
                send_rec_t e;
                e = sends_due.pop_front();
                if (rsp.sent_group !== e.grp || rsp.sent !== e.snt ||
                    rsp.budget_left !== e.left || rsp.last !== e.lst) begin
                    $display("%0t: mismatch expected grp=%0d sent=%0b left=%0d last=%0b",
                             $time, e.grp, e.snt, e.left, e.lst);
                    $display("%0t:          actual   grp=%0d sent=%0b left=%0d last=%0b",
                             $time, rsp.sent_group, rsp.sent, rsp.budget_left,
                             rsp.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    dir_row_t dir_rows [] = '{
        // Empty table: nothing sent, full reset budget.
        '{CMD_TICK,  5'd0,  16'd0,     8'd0,   1'b1, '{5'd0, 1'b0, 8'd30, 1'b1}},
        '{CMD_WRITE, 5'd0,  16'd1,     8'd10,  1'b0, '0},
        '{CMD_WRITE, 5'd31, 16'd1,     8'd255, 1'b0, '0},
        '{CMD_WRITE, 5'd1,  16'd1,     8'd0,   1'b0, '0},
        '{CMD_WRITE, 5'd2,  16'd65535, 8'd5,   1'b0, '0},
        '{CMD_WRITE, 5'd3,  16'd2,     8'd25,  1'b0, '0},
        '{CMD_TICK,  5'd31, 16'hFFFF,  8'hFF,  1'b0, '0},
        '{CMD_TICK,  5'd0,  16'd0,     8'd0,   1'b0, '0},
        '{CMD_TICK,  5'd0,  16'd0,     8'd0,   1'b0, '0},
        // Disable a pending group; its flag must survive until re-enabled.
        '{CMD_WRITE, 5'd3,  16'd0,     8'd25,  1'b0, '0},
        '{CMD_TICK,  5'd0,  16'd0,     8'd0,   1'b0, '0},
        '{CMD_WRITE, 5'd3,  16'd7,     8'd1,   1'b0, '0},
        '{CMD_TICK,  5'd0,  16'd0,     8'd0,   1'b0, '0},
        '{CMD_WRITE, 5'd0,  16'd0,     8'd0,   1'b0, '0},
        '{CMD_WRITE, 5'd31, 16'd0,     8'd0,   1'b0, '0},
        '{CMD_WRITE, 5'd1,  16'd0,     8'd0,   1'b0, '0},
        '{CMD_WRITE, 5'd2,  16'd0,     8'd0,   1'b0, '0},
        '{CMD_WRITE, 5'd3,  16'd0,     8'd0,   1'b0, '0},
        '{CMD_TICK,  5'd0,  16'd0,     8'd0,   1'b1, '{5'd0, 1'b0, 8'd30, 1'b1}}
    };

    initial begin
        send_rec_t chk;
        clk         = 1'b0;
        rst_n       = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        stim_done   = 1'b0;
        req.valid       = 1'b0;
        req.command     = CMD_TICK;
        req.group_index = '0;
        req.period      = '0;
        req.byte_size   = '0;
        cfg.valid   = 1'b0;
        cfg.data    = '0;
        ctl.quiet     = 1'b0;
        ctl.stall_pct = 4'd4;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            sh_period[g] = '0;
            sh_size[g]   = '0;
            sh_pend[g]   = 1'b0;
        end
        sh_tick   = '0;
        sh_budget = BUDGET_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed rows must agree with the predictor.
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].per,
                      dir_rows[i].sz);
            if (dir_rows[i].has_exp) begin
                chk = sends_due[$];
                if (chk !== dir_rows[i].exp) begin
                    $display("%0t: table row %0d expected %h, predictor %h",
                             $time, i, dir_rows[i].exp, chk);
                    fail_count++;
                end
            end
        end
        finish_item_stream();
        drain();

        // Random phases across budget settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_budget(8'd0);
                1: write_budget(8'd255);
                2: write_budget(8'd1);
                3: write_budget(SIZE_W'($urandom_range(10, 80)));
                4: write_budget(SIZE_W'($urandom_range(1, 255)));
                default: write_budget(8'd30);
            endcase
            ctl.quiet     = (ph == 3);
            ctl.stall_pct = 4'($urandom_range(0, 12));
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
                random_item();
            finish_item_stream();
            drain();
        end

        stim_done = 1'b1;
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
